// ----- rtl/sfcf_pkg.sv -----
// Shared types and constants for the serial command frame finder.
// No dependencies.
`default_nettype none

package sfcf_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 2'd2;

    localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'd90;
    localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'd165;
    localparam logic [BYTE_W-1:0] RST_MAX_FRAME_LEN = 8'd255;

    localparam logic [BYTE_W-1:0] LEN_BYTE_INDEX = 8'd3;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_LAST  = 2'd1,
        KIND_ERROR = 2'd2
    } sfcf_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] idx;
        sfcf_kind_t        kind;
    } sfcf_item_t;

endpackage

`default_nettype wire

// ----- rtl/sfcf_front.sv -----
// Front end: configuration registers, hunt position tracking and word classification.
// Depends on sfcf_pkg.
`default_nettype none

module sfcf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sfcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sfcf_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [sfcf_pkg::BYTE_W-1:0]    rx_byte,
    input  wire logic                          restart,
    output logic                               push,
    output sfcf_pkg::sfcf_item_t               push_item,
    input  wire logic                          q_full
);
    import sfcf_pkg::*;

    logic [BYTE_W-1:0] hdr_first_reg;
    logic [BYTE_W-1:0] hdr_second_reg;
    logic [BYTE_W-1:0] max_len_reg;
    logic [BYTE_W-1:0] pos_reg, pos_next;
    logic [BYTE_W-1:0] dlen_reg, dlen_next;
    logic              accept;
    logic [BYTE_W-1:0] len_eff;
    logic [BYTE_W:0]   count;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign len_eff  = (pos_reg == LEN_BYTE_INDEX) ? rx_byte : dlen_reg;
    assign count    = {1'b0, pos_reg} + {{BYTE_W{1'b0}}, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= RST_HEADER_FIRST;
            hdr_second_reg <= RST_HEADER_SECOND;
            max_len_reg    <= RST_MAX_FRAME_LEN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_FIRST:  hdr_first_reg  <= cfg_data;
                CFG_HEADER_SECOND: hdr_second_reg <= cfg_data;
                CFG_MAX_FRAME_LEN: max_len_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        dlen_next      = dlen_reg;
        push           = 1'b0;
        push_item.data = rx_byte;
        push_item.idx  = pos_reg;
        push_item.kind = KIND_DATA;
        if (accept)
        begin
            if (restart)
            begin
                pos_next  = '0;
                dlen_next = '0;
            end
            else if (pos_reg == '0 && rx_byte != hdr_first_reg)
            begin
                pos_next = pos_reg;
            end
            else if (pos_reg == 8'd1 && rx_byte != hdr_second_reg)
            begin
                pos_next = '0;
            end
            else if (pos_reg >= max_len_reg)
            begin
                push           = 1'b1;
                push_item.kind = KIND_ERROR;
                pos_next       = '0;
            end
            else
            begin
                push = 1'b1;
                if (pos_reg == LEN_BYTE_INDEX)
                    dlen_next = rx_byte;
                if (pos_reg >= LEN_BYTE_INDEX
                    && count == ({1'b0, len_eff} + {{BYTE_W{1'b0}}, 1'b1}))
                begin
                    push_item.kind = KIND_LAST;
                    pos_next       = '0;
                end
                else
                begin
                    pos_next = count[BYTE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            dlen_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            dlen_reg <= dlen_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfcf_queue.sv -----
// Two-entry queue of classified words between front and back ends.
// Depends on sfcf_pkg.
`default_nettype none

module sfcf_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire sfcf_pkg::sfcf_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output sfcf_pkg::sfcf_item_t    pop_item,
    output logic                    empty
);
    import sfcf_pkg::*;

    sfcf_item_t  slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_push, do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfcf_back.sv -----
// Back end: turns classified words into result fields in an output register.
// Depends on sfcf_pkg.
`default_nettype none

module sfcf_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_empty,
    input  wire sfcf_pkg::sfcf_item_t       q_item,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [sfcf_pkg::BYTE_W-1:0]     frame_byte,
    output logic [sfcf_pkg::BYTE_W-1:0]     byte_index,
    output logic                            frame_last,
    output logic [sfcf_pkg::BYTE_W-1:0]     frame_length,
    output logic                            frame_error
);
    import sfcf_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] idx_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] len_reg;
    logic              err_reg;

    assign q_pop = !q_empty && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            byte_reg <= q_item.data;
            idx_reg  <= q_item.idx;
            last_reg <= (q_item.kind == KIND_LAST);
            err_reg  <= (q_item.kind == KIND_ERROR);
            len_reg  <= (q_item.kind == KIND_LAST) ? (q_item.idx + 8'd1) : '0;
        end
    end

    assign out_valid    = valid_reg;
    assign frame_byte   = byte_reg;
    assign byte_index   = idx_reg;
    assign frame_last   = last_reg;
    assign frame_length = len_reg;
    assign frame_error  = err_reg;

endmodule

`default_nettype wire

// ----- rtl/serial_command_frame_finder.sv -----
// Top level of the serial command frame finder: front end, word queue, back end.
// Depends on sfcf_pkg, sfcf_front, sfcf_queue, sfcf_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | rx_byte, restart
//  output   | out_valid / out_stall| frame_byte, byte_index, frame_last,
//           |                      | frame_length, frame_error
//  config   | cfg_we               | cfg_index, cfg_data
//
// One word per cycle while the queue is not full; a result passes a queue slot, then the output register.
// in_stall rises only when the two-entry queue is full under output stall.
// Reset restores the header and capacity registers and clears the hunt position.
`default_nettype none

module serial_command_frame_finder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sfcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sfcf_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [sfcf_pkg::BYTE_W-1:0]    rx_byte,
    input  wire logic                          restart,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [sfcf_pkg::BYTE_W-1:0]        frame_byte,
    output logic [sfcf_pkg::BYTE_W-1:0]        byte_index,
    output logic                               frame_last,
    output logic [sfcf_pkg::BYTE_W-1:0]        frame_length,
    output logic                               frame_error
);
    import sfcf_pkg::*;

    logic       push;
    sfcf_item_t push_item;
    logic       q_full;
    logic       q_pop;
    sfcf_item_t q_item;
    logic       q_empty;

    sfcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .restart   (restart),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    sfcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    sfcf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .byte_index   (byte_index),
        .frame_last   (frame_last),
        .frame_length (frame_length),
        .frame_error  (frame_error)
    );

endmodule

`default_nettype wire
